// ===== src/htsd_pkg.sv =====
package htsd_pkg;

  localparam int SYMBOLS      = 256;
  localparam int SYM_W        = 8;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_W        = 6;
  localparam int CODE_W       = 32;
  localparam int BITS_W       = 4;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_bits;
    logic [7:0]        data_byte;
    logic [BITS_W-1:0] valid_bits;
    logic              stream_end;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] decoded_symbol;
    logic             status;
    logic             last;
  } out_item_t;

  // Requests from the sequencer to the code table.
  typedef struct packed {
    logic              wr_en;
    logic              clr;
    logic              rd_en;
    logic [SYM_W-1:0]  wr_addr;
    logic [SYM_W-1:0]  rd_addr;
    logic [LEN_W-1:0]  wr_len;
    logic [CODE_W-1:0] wr_code;
  } tbl_req_t;

endpackage

// ===== src/htsd_in_if.sv =====
interface htsd_in_if import htsd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/htsd_out_if.sv =====
interface htsd_out_if import htsd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/huffman_table_stream_decoder_unit.sv =====
// Huffman decoder with a freely loaded code table of SYMBOLS entries. A load or
// clear transfer leaves the block ready again right after it. A data transfer
// shifts its valid bits into the prefix one at a time, and for each bit the
// table memory, which has a single read port, is scanned one entry per cycle
// from the highest symbol down, stopping at the first match. Results pass
// through a one-entry holding register, which keeps the newest result until it
// is known whether it is the last one, and then an output register. The decoder
// pauses when a new result finds both registers occupied and the output not
// taken, and at the end of a data transfer it waits until the held result can
// move to the output register. No clearing pass follows reset.
module huffman_table_stream_decoder_unit import htsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  htsd_in_if.sink     stream_in_i,
  htsd_out_if.source  result_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BIT  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CODE_W-1:0] prefix_q, prefix_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [7:0]        byte_q, byte_d;
  logic [BITS_W-1:0] bits_left_q, bits_left_d;
  logic              end_q, end_d;
  logic [SYM_W-1:0]  scan_addr_q, scan_addr_d;
  logic              issued_all_q, issued_all_d;
  logic              rd_v_q, rd_v_d;
  logic [SYM_W-1:0]  rd_sym_q, rd_sym_d;
  logic              pend_v_q, pend_v_d;
  logic [SYM_W-1:0]  pend_sym_q, pend_sym_d;
  logic              pend_st_q, pend_st_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;

  tbl_req_t          req;
  logic              tbl_hit;
  logic              in_acc;
  logic              out_free;
  logic              can_emit;
  logic              hit;
  logic              exhausted;
  logic              res_now;
  logic [SYM_W-1:0]  res_sym;
  logic              res_st;
  in_item_t          item;

  htsd_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .prefix_i (prefix_q),
    .plen_i   (plen_q),
    .hit_o    (tbl_hit)
  );

  assign item              = stream_in_i.data;
  assign stream_in_i.ready = (state_q == S_IDLE);
  assign in_acc            = stream_in_i.valid && stream_in_i.ready;
  assign result_o.valid    = out_v_q;
  assign result_o.data     = out_q;

  assign out_free  = !out_v_q || result_o.ready;
  assign can_emit  = !pend_v_q || out_free;
  assign hit       = rd_v_q && tbl_hit;
  assign exhausted = rd_v_q && !tbl_hit && (rd_sym_q == '0);

  always_comb begin
    state_d      = state_q;
    prefix_d     = prefix_q;
    plen_d       = plen_q;
    byte_d       = byte_q;
    bits_left_d  = bits_left_q;
    end_d        = end_q;
    scan_addr_d  = scan_addr_q;
    issued_all_d = issued_all_q;
    rd_v_d       = rd_v_q;
    rd_sym_d     = rd_sym_q;
    pend_v_d     = pend_v_q;
    pend_sym_d   = pend_sym_q;
    pend_st_d    = pend_st_q;
    out_v_d      = out_v_q;
    out_d        = out_q;
    req          = '0;
    res_now      = 1'b0;
    res_sym      = '0;
    res_st       = STATUS_OK;

    if (out_v_q && result_o.ready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (item.action)
            ACT_LOAD: begin
              req.wr_en   = 1'b1;
              req.wr_addr = item.symbol;
              req.wr_len  = item.code_length;
              req.wr_code = item.code_bits;
            end
            ACT_CLEAR: begin
              req.clr  = 1'b1;
              prefix_d = '0;
              plen_d   = '0;
            end
            ACT_DATA: begin
              byte_d      = item.data_byte;
              bits_left_d = (item.valid_bits > BITS_W'(8)) ? BITS_W'(8) : item.valid_bits;
              end_d       = item.stream_end;
              state_d     = S_BIT;
            end
            default: begin
            end
          endcase
        end
      end

      S_BIT: begin
        if (bits_left_q != '0) begin
          prefix_d     = {prefix_q[CODE_W-2:0], byte_q[7]};
          plen_d       = plen_q + LEN_W'(1);
          byte_d       = {byte_q[6:0], 1'b0};
          bits_left_d  = bits_left_q - BITS_W'(1);
          scan_addr_d  = SYM_W'(SYMBOLS - 1);
          issued_all_d = 1'b0;
          rd_v_d       = 1'b0;
          state_d      = S_SCAN;
        end else begin
          state_d = S_END;
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_now = 1'b1;
          res_sym = rd_sym_q;
          res_st  = STATUS_OK;
        end else if (exhausted && (plen_q >= LEN_W'(MAX_CODE_LEN))) begin
          res_now = 1'b1;
          res_st  = STATUS_ERR;
        end

        if (res_now && !can_emit) begin
          // Hold the read data until the output side makes room.
        end else if (hit || exhausted) begin
          if (res_now) begin
            prefix_d = '0;
            plen_d   = '0;
          end
          rd_v_d  = 1'b0;
          state_d = S_BIT;
        end else begin
          req.rd_en   = !issued_all_q;
          req.rd_addr = scan_addr_q;
          rd_v_d      = !issued_all_q;
          rd_sym_d    = scan_addr_q;
          if (!issued_all_q) begin
            if (scan_addr_q == '0) begin
              issued_all_d = 1'b1;
            end else begin
              scan_addr_d = scan_addr_q - SYM_W'(1);
            end
          end
        end
      end

      S_END: begin
        if (end_q && (plen_q != '0)) begin
          res_now = 1'b1;
          res_st  = STATUS_ERR;
          if (can_emit) begin
            prefix_d = '0;
            plen_d   = '0;
            state_d  = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_v_d              = 1'b1;
          out_d.decoded_symbol = pend_sym_q;
          out_d.status         = pend_st_q;
          out_d.last           = 1'b1;
          pend_v_d             = 1'b0;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A new result retires the one held back, which then cannot be the last.
    if (res_now && can_emit) begin
      if (pend_v_q) begin
        out_v_d              = 1'b1;
        out_d.decoded_symbol = pend_sym_q;
        out_d.status         = pend_st_q;
        out_d.last           = 1'b0;
      end
      pend_v_d   = 1'b1;
      pend_sym_d = res_sym;
      pend_st_d  = res_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prefix_q     <= '0;
      plen_q       <= '0;
      bits_left_q  <= '0;
      end_q        <= 1'b0;
      issued_all_q <= 1'b0;
      rd_v_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      prefix_q     <= prefix_d;
      plen_q       <= plen_d;
      bits_left_q  <= bits_left_d;
      end_q        <= end_d;
      issued_all_q <= issued_all_d;
      rd_v_q       <= rd_v_d;
      pend_v_q     <= pend_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    scan_addr_q <= scan_addr_d;
    rd_sym_q    <= rd_sym_d;
    pend_sym_q  <= pend_sym_d;
    pend_st_q   <= pend_st_d;
    out_q       <= out_d;
  end

endmodule

// ===== src/htsd_table.sv =====
module htsd_table import htsd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbl_req_t                req_i,
  input  logic [CODE_W-1:0]       prefix_i,
  input  logic [LEN_W-1:0]        plen_i,
  output logic                    hit_o
);

  logic [LEN_W+CODE_W-1:0] mem_q [SYMBOLS];
  logic [LEN_W+CODE_W-1:0] rd_data_q;
  logic                    rd_ok_q;
  logic [SYMBOLS-1:0]      valid_q;
  logic [LEN_W-1:0]        rd_len;
  logic [CODE_W-1:0]       rd_code;
  logic [CODE_W-1:0]       mask;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= {req_i.wr_len, req_i.wr_code};
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
      rd_ok_q   <= valid_q[req_i.rd_addr];
    end
  end

  // An entry that has not been loaded since the last clear reads as invalid and cannot match.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clr) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr] <= 1'b1;
    end
  end

  assign rd_len  = rd_data_q[LEN_W+CODE_W-1:CODE_W];
  assign rd_code = rd_data_q[CODE_W-1:0];
  assign mask    = ~({CODE_W{1'b1}} << plen_i);

  // The prefix is never empty while a scan runs, so length zero cannot match.
  assign hit_o = rd_ok_q && (rd_len == plen_i) && (((rd_code ^ prefix_i) & mask) == '0);

endmodule

// ===== src/htsd_checker.sv =====
module htsd_checker import htsd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input in_item_t  in_data_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result changed");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.action == ACT_DATA) |=> !in_ready_i)
    else $error("data transfer did not occupy the decoder");

  a_ctrl_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_data_i.action != ACT_DATA) |=> in_ready_i)
    else $error("table transfer did not complete in one cycle");

  a_err_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == STATUS_ERR) |-> (out_data_i.decoded_symbol == '0))
    else $error("error result carries a symbol");

endmodule

bind huffman_table_stream_decoder_unit htsd_checker u_htsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (stream_in_i.valid),
  .in_ready_i  (stream_in_i.ready),
  .in_data_i   (stream_in_i.data),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
